### src/meu_pkg.sv
// Shared types and constants for the multiturn encoder unwrap block.
package meu_pkg;

	localparam int ANGLE_W = 13;
	localparam int RATE_W  = 14;
	localparam int TURNS_W = 32;
	localparam int POS_W   = 46;
	localparam int ANG_W   = 51;

	localparam int WIN_LEN = 8;
	localparam int PTR_W   = $clog2(WIN_LEN);
	localparam int SUM_W   = RATE_W + PTR_W;

	localparam logic signed [RATE_W-1:0] WRAP_LOW    = -14'sd6500;
	localparam logic signed [RATE_W-1:0] WRAP_HIGH   = 14'sd6500;
	localparam logic signed [RATE_W-1:0] COUNTS_TURN = 14'sd8192;
	localparam logic signed [6:0]        ANGLE_SCALE = 7'sd45;

	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 160;

	// Unwrap results for one reading.
	typedef struct packed {
		logic signed [ANG_W-1:0]   angle_fixed;
		logic signed [POS_W-1:0]   absolute_position;
		logic signed [TURNS_W-1:0] turn_count;
		logic signed [RATE_W-1:0]  raw_rate;
	} meu_unw_t;

	// Full result word; first member sits in the highest bits.
	typedef struct packed {
		logic signed [ANG_W-1:0]   angle_fixed;
		logic signed [POS_W-1:0]   absolute_position;
		logic signed [TURNS_W-1:0] turn_count;
		logic signed [RATE_W-1:0]  filtered_rate;
		logic signed [RATE_W-1:0]  raw_rate;
	} meu_res_t;

endpackage

### src/meu_unwrap.sv
// Turn unwrap: rate, turn count, absolute position and angle, with its state.
module meu_unwrap
	import meu_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic [ANGLE_W-1:0] reading,
	input  logic [ANGLE_W-1:0] offset,
	output meu_unw_t           unw
);

	logic [ANGLE_W-1:0]         prev_q;
	logic signed [TURNS_W-1:0]  turns_q;
	logic signed [RATE_W-1:0]   diff;
	logic signed [RATE_W-1:0]   rate;
	logic signed [TURNS_W-1:0]  turns_next;
	logic signed [RATE_W-1:0]   rel;
	logic signed [TURNS_W+6:0]  turns_scaled;
	logic signed [20:0]         rel_scaled;

	assign diff = signed'({1'b0, reading}) - signed'({1'b0, prev_q});
	assign rel  = signed'({1'b0, reading}) - signed'({1'b0, offset});

	always_comb begin
		if (diff < WRAP_LOW) begin
			rate       = diff + COUNTS_TURN;
			turns_next = turns_q + 32'sd1;
		end else if (diff > WRAP_HIGH) begin
			rate       = diff - COUNTS_TURN;
			turns_next = turns_q - 32'sd1;
		end else begin
			rate       = diff;
			turns_next = turns_q;
		end
	end

	// 45*(reading - offset + turns*8192), split into the turn and in-turn parts
	assign turns_scaled = {{7{turns_next[TURNS_W-1]}}, turns_next}
		* (TURNS_W+7)'(ANGLE_SCALE);
	assign rel_scaled   = {{7{rel[RATE_W-1]}}, rel} * 21'(ANGLE_SCALE);

	always_comb begin
		unw.raw_rate          = rate;
		unw.turn_count        = turns_next;
		// reading is below one turn, so the sum is a plain concatenation
		unw.absolute_position = signed'({turns_next[TURNS_W-1], turns_next, reading});
		unw.angle_fixed       = signed'({turns_scaled[ANG_W-ANGLE_W-1:0], {ANGLE_W{1'b0}}})
			+ ANG_W'(rel_scaled);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= '0;
			turns_q <= '0;
		end else if (en) begin
			prev_q  <= reading;
			turns_q <= turns_next;
		end
	end

endmodule

### src/meu_window.sv
// Moving average of the rate over a circular window with a running sum.
module meu_window
	import meu_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic signed [RATE_W-1:0] rate,
	output logic signed [RATE_W-1:0] avg
);

	logic signed [RATE_W-1:0] win_q [WIN_LEN];
	logic [PTR_W-1:0]         ptr_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic signed [SUM_W-1:0]  sum_next;

	// drop the oldest entry, add the new one
	assign sum_next = sum_q - SUM_W'(win_q[ptr_q]) + SUM_W'(rate);
	// signed divide by a power of two truncates toward zero
	assign avg = RATE_W'(sum_next / WIN_LEN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WIN_LEN; i++) begin
				win_q[i] <= '0;
			end
			ptr_q <= '0;
			sum_q <= '0;
		end else if (en) begin
			win_q[ptr_q] <= rate;
			sum_q        <= sum_next;
			if (ptr_q == PTR_W'(WIN_LEN - 1)) begin
				ptr_q <= '0;
			end else begin
				ptr_q <= ptr_q + 1'b1;
			end
		end
	end

endmodule

### src/multiturn_encoder_unwrap_core.sv
// Top level of the multiturn encoder unwrap with moving-average rate.
// A word accepted into the input register moves on to the result register, which drives m_tvalid.
// One word per cycle unless stalled: input register, one logic pass, result register.
// Back-pressure on the output stalls the input register through s_tready.
// Reset clears turns, previous reading, window, offset and both valid flags.
module multiturn_encoder_unwrap_core
	import meu_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,  // [12:0] raw_angle
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// [13:0] raw_rate, [27:14] filtered_rate, [59:28] turn_count,
	// [105:60] absolute_position, [156:106] angle_fixed
	output logic [OUT_TDATA_W-1:0] m_tdata,
	input  logic                   cfg_we,
	input  logic [ANGLE_W-1:0]     cfg_wdata
);

	logic [ANGLE_W-1:0] offset_q;
	logic               valid_s1;
	logic [ANGLE_W-1:0] angle_s1;
	logic               valid_s2;
	meu_res_t           res_s2;
	logic               adv_s2;
	logic               adv_s1;
	meu_unw_t           unw;
	logic signed [RATE_W-1:0] avg;

	assign adv_s2   = !valid_s2 || m_tready;
	assign adv_s1   = valid_s1 && adv_s2;
	assign s_tready = !valid_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
		end else if (cfg_we) begin
			offset_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			angle_s1 <= s_tdata[ANGLE_W-1:0];
		end
	end

	meu_unwrap u_unwrap (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv_s1),
		.reading (angle_s1),
		.offset  (offset_q),
		.unw     (unw)
	);

	meu_window u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv_s1),
		.rate   (unw.raw_rate),
		.avg    (avg)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2.angle_fixed       <= unw.angle_fixed;
			res_s2.absolute_position <= unw.absolute_position;
			res_s2.turn_count        <= unw.turn_count;
			res_s2.filtered_rate     <= avg;
			res_s2.raw_rate          <= unw.raw_rate;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {{(OUT_TDATA_W - $bits(meu_res_t)){1'b0}}, res_s2};

endmodule

### src/meu_checker.sv
// Port-level checks for the multiturn encoder unwrap top level, with its bind.
module meu_checker
	import meu_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tready,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata
);

	// hold a stalled result word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	a_rate_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[13:0]) >= -14'sd6500)
			&& ($signed(m_tdata[13:0]) <= 14'sd6500))
		else $error("raw rate outside unwrap range");

	a_filt_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[27:14]) >= -14'sd6500)
			&& ($signed(m_tdata[27:14]) <= 14'sd6500))
		else $error("filtered rate outside unwrap range");

	// upper bits of the position are the turn count
	a_pos_turns: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[104:73] == m_tdata[59:28]) && (m_tdata[105] == m_tdata[59]))
		else $error("position does not match turn count");

	// an empty pipeline never blocks the input
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

endmodule

bind multiturn_encoder_unwrap_core meu_checker u_meu_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

### tb/multiturn_encoder_unwrap_core_tb.sv
// Self-checking testbench for the multiturn encoder unwrap core: directed and random readings.
`timescale 1ns / 1ps

module multiturn_encoder_unwrap_core_tb;
	import meu_pkg::*;

	localparam int WRAP_LIM      = 6500;
	localparam int COUNTS        = 8192;
	localparam int DEG_SCALE     = 45;
	localparam int SETTLE_CYCLES = 6;
	localparam int CYCLE_LIMIT   = 400000;

	logic                   clk;
	logic                   arst_n    = 1'b0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata   = '0;
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   cfg_we    = 1'b0;
	logic [ANGLE_W-1:0]     cfg_wdata = '0;

	// Predictor state
	logic [ANGLE_W-1:0]        offset_mirror = '0;
	int                        last_reading  = 0;
	logic signed [TURNS_W-1:0] turn_ctr      = '0;
	int                        rate_hist[WIN_LEN];
	int                        hist_ptr      = 0;
	int                        hist_sum      = 0;

	meu_res_t expected_words[$];
	bit       failed     = 1'b0;
	bit       calm       = 1'b0;
	int       stall_left = 0;
	int       cycles     = 0;

	multiturn_encoder_unwrap_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic meu_res_t predict_unwrap(input logic [ANGLE_W-1:0] reading);
		int       diff;
		int       rate;
		int       avg;
		longint   t;
		longint   pos;
		longint   ang;
		meu_res_t r;
		diff = int'(reading) - last_reading;
		if (diff < -WRAP_LIM) begin
			turn_ctr = turn_ctr + 1;
			rate = diff + COUNTS;
		end else if (diff > WRAP_LIM) begin
			turn_ctr = turn_ctr - 1;
			rate = diff - COUNTS;
		end else begin
			rate = diff;
		end
		last_reading = int'(reading);
		t = longint'(turn_ctr);
		pos = longint'(reading) + t * COUNTS;
		ang = DEG_SCALE * (longint'(reading) - longint'(offset_mirror) + t * COUNTS);
		hist_sum = hist_sum - rate_hist[hist_ptr] + rate;
		rate_hist[hist_ptr] = rate;
		hist_ptr = (hist_ptr + 1) % WIN_LEN;
		// integer division truncates toward zero, as the block does
		avg = hist_sum / WIN_LEN;
		r.raw_rate          = rate[RATE_W-1:0];
		r.filtered_rate     = avg[RATE_W-1:0];
		r.turn_count        = turn_ctr;
		r.absolute_position = pos[POS_W-1:0];
		r.angle_fixed       = ang[ANG_W-1:0];
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	task automatic send_reading(input logic [ANGLE_W-1:0] reading);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= IN_TDATA_W'(reading);
		do @(posedge clk); while (!s_tready);
		expected_words.push_back(predict_unwrap(reading));
	endtask

	// Hold the input idle until every expected word has come back.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_angle_offset(input logic [ANGLE_W-1:0] value);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		offset_mirror = value;
	endtask

	task automatic send_steps(input int steps[]);
		foreach (steps[i])
			send_reading(ANGLE_W'(last_reading + steps[i]));
	endtask

	// First reading after reset is taken against zero, then the wrap thresholds.
	task automatic test_first_reading_and_wrap();
		send_reading(13'd8191);
		send_reading(13'd8191);
		send_reading(13'd1691);  // -6500: no wrap
		send_reading(13'd8191);  // +6500: no wrap
		send_reading(13'd1690);  // -6501: forward wrap
		send_reading(13'd8191);  // +6501: backward wrap
		send_reading(13'd0);
		send_reading(13'd8191);
		send_reading(13'd0);
		send_reading(13'd1);
	endtask

	// Small negative sums must truncate toward zero, and the pointer wraps.
	task automatic test_window_truncation();
		send_steps('{0, 0, 0, 0, 0, 0, 0, 0, -1, 0, -9, 9, 7, -15});
	endtask

	task automatic test_offset_extremes();
		set_angle_offset(13'd8191);
		send_reading(13'd0);
		send_reading(13'd8191);
		set_angle_offset(13'd0);
		send_reading(13'd4096);
	endtask

	// Continuous motion with a drifting velocity; a share of readings is pure noise.
	task automatic test_tracked_motion(input int n);
		int vel;
		int step;
		for (int k = 0; k < n; k++) begin
			if (k % 32 == 0) begin
				if ($urandom_range(0, 3) == 0)
					vel = $urandom_range(0, 13000) - 6500;
				else
					vel = $urandom_range(0, 800) - 400;
			end
			if ($urandom_range(0, 9) == 0) begin
				send_reading(ANGLE_W'($urandom));
			end else begin
				step = vel + $urandom_range(0, 16) - 8;
				send_reading(ANGLE_W'(last_reading + step));
			end
		end
	endtask

	// Spin fast in each direction to reach the rate extremes.
	task automatic test_fast_spin(input int n);
		int vel;
		vel = $urandom_range(6000, 6500);
		for (int k = 0; k < n; k++) begin
			if (k == n / 2)
				vel = -$urandom_range(6000, 6500);
			send_reading(ANGLE_W'(last_reading + vel));
		end
	endtask

	task automatic test_raw_noise(input int n);
		for (int k = 0; k < n; k++)
			send_reading(ANGLE_W'($urandom));
	endtask

	// Result checker and output stall generator
	always @(posedge clk) begin
		meu_res_t got;
		meu_res_t want;
		int       r;
		if (m_tvalid && m_tready) begin
			got = meu_res_t'(m_tdata[$bits(meu_res_t)-1:0]);
			if (expected_words.size() == 0) begin
				$error("unexpected word: %h", m_tdata);
				failed = 1'b1;
			end else begin
				want = expected_words.pop_front();
				if (got.raw_rate !== want.raw_rate) begin
					$error("raw_rate: expected %0d, got %0d", want.raw_rate, got.raw_rate);
					failed = 1'b1;
				end
				if (got.filtered_rate !== want.filtered_rate) begin
					$error("filtered_rate: expected %0d, got %0d",
						want.filtered_rate, got.filtered_rate);
					failed = 1'b1;
				end
				if (got.turn_count !== want.turn_count) begin
					$error("turn_count: expected %0d, got %0d",
						want.turn_count, got.turn_count);
					failed = 1'b1;
				end
				if (got.absolute_position !== want.absolute_position) begin
					$error("absolute_position: expected %0d, got %0d",
						want.absolute_position, got.absolute_position);
					failed = 1'b1;
				end
				if (got.angle_fixed !== want.angle_fixed) begin
					$error("angle_fixed: expected %0d, got %0d",
						want.angle_fixed, got.angle_fixed);
					failed = 1'b1;
				end
			end
		end
		r = $urandom_range(0, 99);
		if (calm) begin
			m_tready <= 1'b1;
		end else if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else if (r < 60) begin
			m_tready <= 1'b1;
		end else begin
			m_tready <= 1'b0;
			if (r < 90)
				stall_left = $urandom_range(0, 2);
			else if (r < 97)
				stall_left = $urandom_range(3, 11);
			else
				stall_left = $urandom_range(19, 59);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		foreach (rate_hist[i])
			rate_hist[i] = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_first_reading_and_wrap();
		test_window_truncation();
		test_offset_extremes();

		set_angle_offset(13'd8191);
		test_tracked_motion(300);
		set_angle_offset(ANGLE_W'($urandom));
		calm = 1'b1;
		test_fast_spin(200);
		calm = 1'b0;
		set_angle_offset(ANGLE_W'($urandom));
		test_tracked_motion(300);
		set_angle_offset(13'd0);
		test_raw_noise(200);

		drain_results();
		if (!failed && expected_words.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
